[sv/fbs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the first-occurrence byte search core.
// No dependencies.
package fbs_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int COUNT_W     = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_REPORT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_NOT_FOUND = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] match_offset;
  } out_item_t;

  // Per-cycle controls broadcast along the cell row.
  typedef struct packed {
    logic text_shift;
    logic pat_shift;
    logic used_clr;
  } cell_ctrl_t;

endpackage

[sv/fbs_cell.sv]
`timescale 1ns / 1ps
// One cell of the comparator row: a text window byte, a pattern byte and
// an in-use flag, each shifted in from the neighbour. Depends on fbs_pkg.
module fbs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbs_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]         text_i,
  input  logic [7:0]         pat_i,
  input  logic               used_i,
  output logic [7:0]         text_o,
  output logic [7:0]         pat_o,
  output logic               used_o,
  output logic               ok_o
);

  logic [7:0] text_q, text_d;
  logic [7:0] pat_q, pat_d;
  logic       used_q, used_d;

  always_comb begin
    text_d = ctrl_i.text_shift ? text_i : text_q;
    pat_d  = ctrl_i.pat_shift  ? pat_i  : pat_q;
    used_d = used_q;
    if (ctrl_i.used_clr) begin
      used_d = 1'b0;
    end else if (ctrl_i.pat_shift) begin
      used_d = used_i;
    end
  end

  always_ff @(posedge clk_i) begin
    text_q <= text_d;
    pat_q  <= pat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  // An unused cell never blocks a match.
  assign ok_o   = !used_q || (text_q == pat_q);
  assign text_o = text_q;
  assign pat_o  = pat_q;
  assign used_o = used_q;

endmodule

[sv/first_occurrence_byte_search_core.sv]
`timescale 1ns / 1ps
// Top level of the first-occurrence byte search core: control, counters
// and report register around a row of fbs_cell. Depends on fbs_pkg, fbs_cell.

// Takes one item per cycle of any command; an item is stalled only while a
// report result is waiting and the output side stalls. The search runs on a
// row of PATTERN_MAX cells: each text byte shifts into cell 0 and along the
// window, while each pattern byte shifts into cell 0 and along the pattern
// chain, so cell i always pairs the text byte i places back with the pattern
// byte i places from the end. Every cell compares its pair; the match
// decision for a text byte is the AND of all cell results plus the length
// and count checks, taken in the cycle after the byte, and it is folded
// straight into a report arriving in that cycle. A report gives its result
// from a register, in the cycle after acceptance. Clear (command 0) empties the
// pattern and the text side; a report empties only the text side. A pattern
// byte beyond PATTERN_MAX is dropped and flags overflow. No clearing pass
// follows reset: the block is ready in the first cycle.
module first_occurrence_byte_search_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fbs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fbs_pkg::out_item_t out_item_o
);

  localparam int N = fbs_pkg::PATTERN_MAX;
  localparam int LW = fbs_pkg::LEN_W;
  localparam int CW = fbs_pkg::COUNT_W;

  logic                 accept;
  fbs_pkg::cmd_e        cmd;
  fbs_pkg::cell_ctrl_t  ctrl;

  logic [LW-1:0]        len_q, len_d;
  logic                 ovf_q, ovf_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 found_q, found_d;
  logic [CW-1:0]        off_q, off_d;
  logic                 check_q, check_d;
  logic                 out_valid_q, out_valid_d;
  fbs_pkg::out_item_t   out_item_q, out_item_d;

  logic [7:0]           text_chain [N+1];
  logic [7:0]           pat_chain  [N+1];
  logic                 used_chain [N+1];
  logic [N-1:0]         cell_ok;

  logic                 len_full;
  logic [CW-1:0]        len_ext;
  logic                 hit;
  logic                 found_now;
  logic [CW-1:0]        off_now;

  // Hold every item while a result waits on a stalled output.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd        = fbs_pkg::cmd_e'(in_item_i.command);

  assign len_full = (len_q == LW'(N));
  assign len_ext  = CW'(len_q);

  assign ctrl.text_shift = accept && (cmd == fbs_pkg::CMD_TEXT);
  assign ctrl.pat_shift  = accept && (cmd == fbs_pkg::CMD_PATTERN) && !len_full;
  assign ctrl.used_clr   = accept && (cmd == fbs_pkg::CMD_CLEAR);

  // Feed the head of the row; the chains run from cell 0 upward.
  assign text_chain[0] = in_item_i.data_byte;
  assign pat_chain[0]  = in_item_i.data_byte;
  assign used_chain[0] = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    fbs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .text_i (text_chain[i]),
      .pat_i  (pat_chain[i]),
      .used_i (used_chain[i]),
      .text_o (text_chain[i+1]),
      .pat_o  (pat_chain[i+1]),
      .used_o (used_chain[i+1]),
      .ok_o   (cell_ok[i])
    );
  end

  // Decide on the text byte taken last cycle; latch only the first window.
  assign hit = check_q && !found_q && !ovf_q && (len_q != '0) &&
               (count_q >= len_ext) && (&cell_ok);
  assign found_now = found_q || hit;
  assign off_now   = hit ? (count_q - len_ext) : off_q;

  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    count_d     = count_q;
    found_d     = found_now;
    off_d       = off_now;
    check_d     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    if (accept) begin
      unique case (cmd)
        fbs_pkg::CMD_CLEAR: begin
          len_d   = '0;
          ovf_d   = 1'b0;
          count_d = '0;
          found_d = 1'b0;
          off_d   = '0;
        end
        fbs_pkg::CMD_PATTERN: begin
          if (len_full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LW'(1);
          end
        end
        fbs_pkg::CMD_TEXT: begin
          // Saturate the text counter.
          if (count_q != '1) begin
            count_d = count_q + CW'(1);
          end
          check_d = 1'b1;
        end
        fbs_pkg::CMD_REPORT: begin
          out_valid_d = 1'b1;
          out_item_d.match_offset = '0;
          if (ovf_q) begin
            out_item_d.status = fbs_pkg::STAT_OVERFLOW;
          end else if (len_q == '0) begin
            out_item_d.status = fbs_pkg::STAT_FOUND;
          end else if (found_now) begin
            out_item_d.status       = fbs_pkg::STAT_FOUND;
            out_item_d.match_offset = off_now;
          end else begin
            out_item_d.status = fbs_pkg::STAT_NOT_FOUND;
          end
          // Drop the text side; keep the pattern.
          count_d = '0;
          found_d = 1'b0;
          off_d   = '0;
        end
        default: begin
          len_d = len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      found_q     <= 1'b0;
      off_q       <= '0;
      check_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      count_q     <= count_d;
      found_q     <= found_d;
      off_q       <= off_d;
      check_q     <= check_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
